// ----- rtl/array_list_table_engine_macros.svh -----
// Assertion macros for the array list table engine RTL.
`ifndef ARRAY_LIST_TABLE_ENGINE_MACROS_SVH
`define ARRAY_LIST_TABLE_ENGINE_MACROS_SVH

// Same-cycle implication, checked on clk outside reset.
`define ALT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("array list table engine: assertion failed");

// Next-cycle implication, checked on clk outside reset.
`define ALT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("array list table engine: assertion failed");

`endif

// ----- rtl/alt_pkg.sv -----
// Package: command and status codes, beat payloads and cell control for the list engine.
`default_nettype none

package alt_pkg;

	localparam int POS_W   = 7;
	localparam int VAL_W   = 32;
	localparam int FOUND_W = 6;
	localparam int FILL_W  = 7;

	localparam logic [1:0] CMD_FIND   = 2'd0;
	localparam logic [1:0] CMD_MODIFY = 2'd1;
	localparam logic [1:0] CMD_APPEND = 2'd2;
	localparam logic [1:0] CMD_REMOVE = 2'd3;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_RANGE     = 2'd2;
	localparam logic [1:0] STAT_FULL      = 2'd3;

	typedef struct packed {
		logic [1:0]              command;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] item_value;
	} alt_cmd_t;

	typedef struct packed {
		logic [1:0]              status;
		logic [FOUND_W-1:0]      found_position;
		logic signed [VAL_W-1:0] old_value;
		logic signed [VAL_W-1:0] new_value;
		logic [FILL_W-1:0]       fill_count;
	} alt_res_t;

	typedef struct packed {
		logic                    exec;
		logic [1:0]              op;
		logic [POS_W-1:0]        pos;
		logic signed [VAL_W-1:0] value;
	} alt_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/alt_chan_if.sv -----
// Interface: valid/ready channel carrying one payload beat.
`default_nettype none

interface alt_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/alt_cell.sv -----
// Cell: one list entry with its compare, write and shift-from-neighbor logic.
`default_nettype none

module alt_cell #(
	parameter int INDEX = 0,
	parameter int CW    = 7
) (
	input  logic                              clk,
	input  alt_pkg::alt_ctl_t                 ctl,
	input  logic [CW-1:0]                     count,
	input  logic signed [alt_pkg::VAL_W-1:0]  next_entry,
	output logic signed [alt_pkg::VAL_W-1:0]  entry,
	output logic                              hit,
	output logic signed [alt_pkg::VAL_W-1:0]  pick
);
	import alt_pkg::*;

	localparam int CMPW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CMPW-1:0] IDX_C  = CMPW'(INDEX);
	localparam logic [CMPW-1:0] IDX_N  = CMPW'(INDEX + 1);

	logic signed [VAL_W-1:0] entry_q;
	logic [CMPW-1:0]         cnt_w;
	logic [CMPW-1:0]         pos_w;
	logic                    live;
	logic                    at_pos;
	logic                    tail;

	assign cnt_w  = CMPW'(count);
	assign pos_w  = CMPW'(ctl.pos);
	assign live   = IDX_C < cnt_w;
	assign at_pos = IDX_C == pos_w;
	// shift down from the removed slot up to the cell below the old last entry
	assign tail   = (IDX_C >= pos_w) && (IDX_N < cnt_w);

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			unique case (ctl.op)
				CMD_MODIFY: begin
					if (live && at_pos) entry_q <= ctl.value;
				end
				CMD_APPEND: begin
					if (IDX_C == cnt_w) entry_q <= ctl.value;
				end
				CMD_REMOVE: begin
					if (tail) entry_q <= next_entry;
				end
				default: begin
				end
			endcase
		end
	end

	assign entry = entry_q;
	assign hit   = live && (entry_q == ctl.value);
	assign pick  = at_pos ? entry_q : '0;

endmodule

`default_nettype wire

// ----- rtl/array_list_table_engine.sv -----
// Top level: fixed-capacity packed list engine built from a row of entry cells.
//
// Usage:
//   cmd_ch (sink) takes one command beat: command, position, item_value.
//   res_ch (source) gives one result beat per command: status, found_position,
//   old_value, new_value, fill_count.
//   Each list entry lives in its own cell; a remove moves every later entry
//   down one cell together, and all cells compare against a find value at once.
// Sequence:
//   Each command is taken into a held register, executed on every cell, then
//   pushed into the output register; a find runs the lowest-match scan over the
//   hit vector in a scan state between execute and push.
//   The command sequencer runs one command at a time.
// Reset:
//   arst_n clears the fill count, the sequencer and the output valid; entry
//   contents are not cleared and are only read once written.
// Stall:
//   A result waits in the output register while res_ch.ready is low; the
//   next command is still taken and executed, and its result holds in the
//   sequencer until the output register frees.
`default_nettype none
`include "array_list_table_engine_macros.svh"

module array_list_table_engine #(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	alt_chan_if.sink    cmd_ch,
	alt_chan_if.source  res_ch
);
	import alt_pkg::*;

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_PUSH = 2'd3;

	logic [1:0]              state_q;
	logic [CW-1:0]           count_q;
	logic                    out_valid_q;
	alt_cmd_t                cmd_q;
	alt_res_t                res_q;
	alt_res_t                out_q;
	logic [CAPACITY-1:0]     hit_q;

	alt_ctl_t                ctl;
	logic [CAPACITY-1:0]     hit;
	logic signed [VAL_W-1:0] entry [CAPACITY];
	logic signed [VAL_W-1:0] pick  [CAPACITY];
	logic signed [VAL_W-1:0] pick_any;
	logic                    in_range;
	logic                    full;
	logic [CW-1:0]           count_nxt;
	alt_res_t                exec_res;
	logic [CAPACITY-1:0]     low_hit;
	logic [IW-1:0]           found_idx;
	logic                    out_free;
	logic                    append_full;

	// Drive every cell from the held command while executing.
	assign ctl = '{
		exec:  (state_q == S_EXEC),
		op:    cmd_q.command,
		pos:   cmd_q.position,
		value: cmd_q.item_value
	};

	// Row of cells; each takes its upper neighbor's entry on a remove.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		localparam int NXT = (g + 1 < CAPACITY) ? g + 1 : g;
		alt_cell #(
			.INDEX (g),
			.CW    (CW)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.count      (count_q),
			.next_entry (entry[NXT]),
			.entry      (entry[g]),
			.hit        (hit[g]),
			.pick       (pick[g])
		);
	end

	// Only the addressed cell drives a nonzero pick; OR them together.
	always_comb begin
		pick_any = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			pick_any = pick_any | pick[i];
		end
	end

	assign in_range = CMPW'(cmd_q.position) < CMPW'(count_q);
	assign full     = (count_q == CAP_C);

	// Result and next fill count of the command being executed.
	always_comb begin
		count_nxt               = count_q;
		exec_res.status         = STAT_OK;
		exec_res.found_position = '0;
		exec_res.old_value      = '0;
		exec_res.new_value      = '0;
		unique case (cmd_q.command)
			CMD_FIND: begin
				exec_res.status = STAT_NOT_FOUND;
			end
			CMD_MODIFY: begin
				if (!in_range) begin
					exec_res.status = STAT_RANGE;
				end else begin
					exec_res.old_value = pick_any;
					exec_res.new_value = cmd_q.item_value;
				end
			end
			CMD_APPEND: begin
				if (full) begin
					exec_res.status = STAT_FULL;
				end else begin
					count_nxt = count_q + CW'(1);
				end
			end
			CMD_REMOVE: begin
				if (!in_range) begin
					exec_res.status = STAT_RANGE;
				end else begin
					count_nxt = count_q - CW'(1);
				end
			end
			default: begin
			end
		endcase
		exec_res.fill_count = FILL_W'(count_nxt);
	end

	// Isolate the lowest hit, then encode its index.
	assign low_hit = hit_q & (~hit_q + CAPACITY'(1));

	always_comb begin
		found_idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (low_hit[i]) found_idx = found_idx | IW'(i);
		end
	end

	assign out_free = !out_valid_q || res_ch.ready;

	// Control state: sequencer, fill count, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_ch.valid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					count_q <= count_nxt;
					state_q <= (cmd_q.command == CMD_FIND) ? S_SCAN : S_PUSH;
				end
				S_SCAN: begin
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (state_q == S_PUSH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: held command, pending result, output beat.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_ch.valid) cmd_q <= cmd_ch.payload;
		if (state_q == S_EXEC) begin
			res_q <= exec_res;
			hit_q <= hit;
		end
		if (state_q == S_SCAN && (|hit_q)) begin
			res_q.status         <= STAT_OK;
			res_q.found_position <= FOUND_W'(found_idx);
		end
		if (state_q == S_PUSH && out_free) out_q <= res_q;
	end

	assign cmd_ch.ready   = (state_q == S_IDLE);
	assign res_ch.valid   = out_valid_q;
	assign res_ch.payload = out_q;

	assign append_full = (state_q == S_EXEC) && (cmd_q.command == CMD_APPEND) && full;

	// The fill count never passes the capacity.
	`ALT_ASSERT_IMP(a_count_cap, 1'b1, count_q <= CAP_C)
	// An accepted command beat always moves the sequencer into execute.
	`ALT_ASSERT_NEXT(a_accept_exec, cmd_ch.valid && cmd_ch.ready, state_q == S_EXEC)
	// The fill count changes only in the execute cycle.
	`ALT_ASSERT_NEXT(a_count_hold, state_q != S_EXEC, $stable(count_q))
	// An append on a full list reports full and leaves the count alone.
	`ALT_ASSERT_NEXT(a_full_append, append_full, res_q.status == STAT_FULL && $stable(count_q))
	// A result beat appears only after the push state.
	`ALT_ASSERT_IMP(a_push_src, $rose(out_valid_q), $past(state_q) == S_PUSH)

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking testbench for the array list table engine.
`timescale 1ns / 1ps

module testbench;

	import alt_pkg::*;

	localparam int LIST_DEPTH   = 64;
	localparam int SEGMENT_LEN  = 150;
	localparam int PHASE_ITEMS  = 450;
	localparam int TAIL_CYCLES  = 20;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int REPORT_LIMIT = 10;

	// Mirror of the packed list: predicts one result beat per accepted command beat
	// and checks returned beats in order.
	class list_scoreboard;
		logic signed [VAL_W-1:0] shadow [LIST_DEPTH];
		int unsigned fill;
		alt_res_t pending [$];
		int unsigned mismatches;
		int unsigned results_seen;
		int unsigned status_tally [4];
		int unsigned command_tally [4];

		function new();
			fill = 0;
			mismatches = 0;
			results_seen = 0;
			foreach (shadow[i]) shadow[i] = '0;
			foreach (status_tally[i]) begin
				status_tally[i] = 0;
				command_tally[i] = 0;
			end
		endfunction

		// Apply one command to the mirror and queue the result it must produce.
		function void note_command(alt_cmd_t c);
			alt_res_t r;
			int i;
			r = '0;
			r.status = STAT_OK;
			case (c.command)
			CMD_FIND: begin
				r.status = STAT_NOT_FOUND;
				for (i = 0; i < fill; i++) begin
					if (shadow[i] == c.item_value) begin
						r.status = STAT_OK;
						r.found_position = FOUND_W'(i);
						break;
					end
				end
			end
			CMD_MODIFY: begin
				if (c.position >= fill) begin
					r.status = STAT_RANGE;
				end else begin
					r.old_value = shadow[c.position];
					r.new_value = c.item_value;
					shadow[c.position] = c.item_value;
				end
			end
			CMD_APPEND: begin
				if (fill >= LIST_DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					shadow[fill] = c.item_value;
					fill++;
				end
			end
			default: begin
				if (c.position >= fill) begin
					r.status = STAT_RANGE;
				end else begin
					for (i = c.position; i + 1 < fill; i++) shadow[i] = shadow[i + 1];
					fill--;
				end
			end
			endcase
			r.fill_count = FILL_W'(fill);
			command_tally[c.command]++;
			pending.push_back(r);
		endfunction

		// Compare a returned beat against the oldest prediction.
		function void check_result(alt_res_t got);
			alt_res_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result beat: status %0d fill %0d",
						got.status, got.fill_count);
				return;
			end
			want = pending.pop_front();
			results_seen++;
			status_tally[want.status]++;
			if (got.status !== want.status || got.found_position !== want.found_position ||
				got.old_value !== want.old_value || got.new_value !== want.new_value ||
				got.fill_count !== want.fill_count) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("result %0d mismatch (expected/actual): status %0d/%0d found %0d/%0d",
						results_seen, want.status, got.status,
						want.found_position, got.found_position);
					$display("  old %0d/%0d new %0d/%0d fill %0d/%0d",
						want.old_value, got.old_value, want.new_value, got.new_value,
						want.fill_count, got.fill_count);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	alt_chan_if #(.payload_t(alt_cmd_t)) cmd_ch ();
	alt_chan_if #(.payload_t(alt_res_t)) res_ch ();

	array_list_table_engine #(.CAPACITY(LIST_DEPTH)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_ch (cmd_ch),
		.res_ch (res_ch)
	);

	list_scoreboard sb;

	// Idle odds in percent, changed between phases.
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	// Fill count as the stimulus expects it once every issued beat is taken;
	// steers positions toward the live part of the list.
	int unsigned planned_fill = 0;
	int unsigned random_seq = 0;
	int unsigned cycle_count = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Stall the result channel at random; a zero percentage keeps ready high.
	always @(posedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Sample both channels at the edge: note each command beat, check each result beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) sb.note_command(cmd_ch.payload);
			if (res_ch.valid && res_ch.ready) sb.check_result(res_ch.payload);
		end
	end

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, sb.pending.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Present one command beat and hold it until accepted. Returns in the step of the
	// accepting edge with valid still high, so a back-to-back beat needs no second
	// assignment to valid in that step.
	task automatic drive_command(input alt_cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.payload <= c;
		do @(posedge clk); while (!cmd_ch.ready);
		case (c.command)
		CMD_APPEND: if (planned_fill < LIST_DEPTH) planned_fill++;
		CMD_REMOVE: if (c.position < planned_fill) planned_fill--;
		default: ;
		endcase
	endtask

	task automatic issue(input logic [1:0] op, input int unsigned pos,
		input logic signed [VAL_W-1:0] val);
		alt_cmd_t c;
		c.command    = op;
		c.position   = POS_W'(pos);
		c.item_value = val;
		drive_command(c);
	endtask

	// Drop valid and hold off until every predicted result has come back.
	task automatic hold_until_drained();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending.size() != 0);
	endtask

	// Small pool of values so that finds hit and duplicates occur.
	function automatic logic signed [VAL_W-1:0] pool_value(input int unsigned idx);
		case (idx)
		0:       return 32'sh8000_0000;
		1:       return 32'sh7FFF_FFFF;
		2:       return 32'sh0000_0000;
		3:       return -32'sd1;
		4:       return 32'sd1;
		5:       return 32'sh5555_5555;
		6:       return 32'shAAAA_AAAA;
		7:       return 32'sd42;
		8:       return -32'sd42;
		9:       return 32'sh0001_0000;
		10:      return 32'sd7;
		default: return 32'sh7FFF_FFFE;
		endcase
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value();
		if ($urandom_range(9) < 5) return pool_value($urandom_range(11));
		return $urandom;
	endfunction

	// Mostly live indexes, some right at the fill count, some anywhere in range.
	function automatic logic [POS_W-1:0] pick_position();
		int unsigned roll;
		roll = $urandom_range(9);
		if (planned_fill != 0 && roll < 7) return POS_W'($urandom_range(planned_fill - 1));
		if (roll < 8) return POS_W'(planned_fill);
		return POS_W'($urandom_range(127));
	endfunction

	// Segments cycle through grow, mixed and shrink mixes so the list swings between
	// full and empty.
	function automatic alt_cmd_t random_command(input int unsigned seq);
		alt_cmd_t c;
		int unsigned roll;
		roll = $urandom_range(99);
		case ((seq / SEGMENT_LEN) % 3)
		0: c.command = (roll < 55) ? CMD_APPEND : (roll < 75) ? CMD_FIND :
			(roll < 90) ? CMD_MODIFY : CMD_REMOVE;
		1: c.command = (roll < 25) ? CMD_APPEND : (roll < 50) ? CMD_FIND :
			(roll < 75) ? CMD_MODIFY : CMD_REMOVE;
		default: c.command = (roll < 45) ? CMD_REMOVE : (roll < 65) ? CMD_FIND :
			(roll < 80) ? CMD_MODIFY : CMD_APPEND;
		endcase
		c.position   = pick_position();
		c.item_value = pick_value();
		return c;
	endfunction

	// One phase of random beats; pause halfway until the block has drained.
	task automatic run_random_phase(input int unsigned n_items, input int unsigned s_idle,
		input int unsigned r_idle);
		int unsigned k;
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		for (k = 0; k < n_items; k++) begin
			if (k == n_items / 2) hold_until_drained();
			drive_command(random_command(random_seq));
			random_seq++;
		end
		hold_until_drained();
	endtask

	initial begin
		sb = new();
		arst_n         <= 1'b0;
		cmd_ch.valid   <= 1'b0;
		cmd_ch.payload <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 23;
		recv_idle_pct = 75;

		// Empty list: every command but append must fail.
		issue(CMD_FIND, 0, 32'sd0);
		issue(CMD_MODIFY, 0, 32'sd5);
		issue(CMD_REMOVE, 0, 32'sd0);
		// Load extremes and a duplicate of the maximum.
		issue(CMD_APPEND, 0, 32'sh8000_0000);
		issue(CMD_APPEND, 0, 32'sh7FFF_FFFF);
		issue(CMD_APPEND, 0, 32'sh0000_0000);
		issue(CMD_APPEND, 0, -32'sd1);
		issue(CMD_APPEND, 0, 32'sh7FFF_FFFF);
		issue(CMD_APPEND, 127, 32'sh5555_5555);
		issue(CMD_APPEND, 0, 32'shAAAA_AAAA);
		// Lowest match wins; a missing value reports not found.
		issue(CMD_FIND, 0, 32'sh7FFF_FFFF);
		issue(CMD_FIND, 127, -32'sd1);
		issue(CMD_FIND, 0, 32'sh1234_5678);
		issue(CMD_MODIFY, 0, 32'sh7FFF_FFFF);
		issue(CMD_FIND, 0, 32'sh7FFF_FFFF);
		issue(CMD_MODIFY, 6, 32'sh8000_0000);
		// Index at the fill count and at the top of the field are out of range.
		issue(CMD_MODIFY, 7, 32'sd9);
		issue(CMD_MODIFY, 127, -32'sd1);
		issue(CMD_REMOVE, 127, 32'sd0);
		// Remove from the middle, the tail and the head.
		issue(CMD_REMOVE, 2, 32'sd0);
		issue(CMD_REMOVE, 5, 32'sd0);
		issue(CMD_REMOVE, 0, 32'sd0);
		issue(CMD_FIND, 0, 32'sh5555_5555);
		issue(CMD_REMOVE, 4, 32'sd0);
		hold_until_drained();

		run_random_phase(PHASE_ITEMS, 23, 75);
		run_random_phase(PHASE_ITEMS, 75, 23);
		run_random_phase(PHASE_ITEMS, 0, 0);

		// Let any stray beat surface before the verdict.
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d results: %0d finds, %0d modifies, %0d appends, %0d removes",
			sb.results_seen, sb.command_tally[CMD_FIND], sb.command_tally[CMD_MODIFY],
			sb.command_tally[CMD_APPEND], sb.command_tally[CMD_REMOVE]);
		$display("outcomes: %0d ok, %0d not found, %0d out of range, %0d full; %0d mismatches",
			sb.status_tally[STAT_OK], sb.status_tally[STAT_NOT_FOUND],
			sb.status_tally[STAT_RANGE], sb.status_tally[STAT_FULL], sb.mismatches);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
